[hw/rtl/fern_pkg.sv]
// ----------------------------------------------------------------------------
// fern_pkg
// Types, coefficients and helper functions shared by the fern IFS point
// generator and its datapath units.
// ----------------------------------------------------------------------------
package fern_pkg;

    localparam int STATE_W   = 24;
    localparam int COEF_W    = 17;
    localparam int COEF_FRAC = 16;
    localparam int OUT_FRAC  = 14;
    localparam int OUT_W     = 16;
    localparam int RED_W     = 15;
    localparam int ADD_W     = 34;
    localparam int PROD_W    = STATE_W + COEF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int PROJ_W    = 40;

    // Map coefficients, signed with 16 fraction bits.
    localparam logic signed [COEF_W-1:0] K_0_16 = 17'sd10486;
    localparam logic signed [COEF_W-1:0] K_0_20 = 17'sd13107;
    localparam logic signed [COEF_W-1:0] K_0_26 = 17'sd17039;
    localparam logic signed [COEF_W-1:0] K_0_23 = 17'sd15073;
    localparam logic signed [COEF_W-1:0] K_0_22 = 17'sd14418;
    localparam logic signed [COEF_W-1:0] K_0_15 = 17'sd9830;
    localparam logic signed [COEF_W-1:0] K_0_28 = 17'sd18350;
    localparam logic signed [COEF_W-1:0] K_0_24 = 17'sd15729;
    localparam logic signed [COEF_W-1:0] K_0_85 = 17'sd55706;
    localparam logic signed [COEF_W-1:0] K_0_04 = 17'sd2621;

    // Projection constants.
    localparam logic signed [PROJ_W-1:0] K_SCALE = 40'sd11141;
    localparam logic signed [PROJ_W-1:0] K_RED   = 40'sd8913;
    localparam logic signed [PROJ_W-1:0] OFF_X   = 40'sd3277;
    localparam logic signed [PROJ_W-1:0] OFF_Y   = 40'sd13107;

    // Additive constants with 32 fraction bits.
    localparam logic signed [63:0] C32_1_60 = 64'sd6871947674;
    localparam logic signed [63:0] C32_0_44 = 64'sd1889785610;

    // Additive constant selection.
    localparam logic [1:0] ADD_NONE = 2'd0;
    localparam logic [1:0] ADD_1_60 = 2'd1;
    localparam logic [1:0] ADD_0_44 = 2'd2;

    typedef struct packed {
        logic [6:0] draw;
        logic       start_new;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic [RED_W-1:0]        red_level;
    } out_item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] ax;
        logic signed [COEF_W-1:0] bx;
        logic signed [COEF_W-1:0] ay;
        logic signed [COEF_W-1:0] by;
        logic [1:0]               add_sel;
    } map_coef_t;

    function automatic map_coef_t map_select(input logic [6:0] draw);
        map_coef_t c;
        priority if (draw <= 7'd1)
        begin
            c = '{ax: '0, bx: '0, ay: '0, by: K_0_16, add_sel: ADD_NONE};
        end
        else if (draw <= 7'd8)
        begin
            c = '{ax: K_0_20, bx: -K_0_26, ay: K_0_23, by: K_0_22, add_sel: ADD_1_60};
        end
        else if (draw <= 7'd15)
        begin
            c = '{ax: -K_0_15, bx: K_0_28, ay: K_0_26, by: K_0_24, add_sel: ADD_0_44};
        end
        else
        begin
            c = '{ax: K_0_85, bx: K_0_04, ay: -K_0_04, by: K_0_85, add_sel: ADD_1_60};
        end
        return c;
    endfunction

    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > 42'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -42'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROJ_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > 40'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -40'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [RED_W-1:0] clamp_red(input logic signed [PROJ_W-1:0] v);
        logic [RED_W-1:0] r;
        if (v > 40'sd32767)
        begin
            r = 15'h7FFF;
        end
        else if (v < 40'sd0)
        begin
            r = '0;
        end
        else
        begin
            r = v[RED_W-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/fern_ifs_point_generator_core.sv]
// ----------------------------------------------------------------------------
// fern_ifs_point_generator_core
// Barnsley fern point generator: emits the projected current point and moves
// it by the affine map that the draw selects.
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-------------------------------
//   input    | item_valid    | item_stall    | item   (draw, start_new)
//   output   | result_valid  | result_stall  | result (point_x, point_y, red)
//
// One item per cycle sustained while result_stall is low. An item passes the
// input register and then the result register before result_valid rises.
// An input register feeds one combinational pass (map and projection
// multiply-adds) that loads the result register and the point state in the
// same cycle. Reset clears the point to the origin and empties both
// registers. A stalled output holds the result and the input register; the
// input side stalls only while its register is also full.
// ----------------------------------------------------------------------------
module fern_ifs_point_generator_core #(
    parameter int STATE_FRAC_BITS = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  fern_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output fern_pkg::out_item_t result
);

    logic                                  in_valid_reg, in_valid_next;
    fern_pkg::in_item_t                    in_item_reg;
    logic                                  out_valid_reg, out_valid_next;
    fern_pkg::out_item_t                   out_item_reg;
    logic signed [fern_pkg::STATE_W-1:0]   cur_x_reg, cur_y_reg;
    logic signed [fern_pkg::STATE_W-1:0]   cur_x_next, cur_y_next;
    logic signed [fern_pkg::STATE_W-1:0]   eff_x, eff_y;
    fern_pkg::out_item_t                   proj;
    logic                                  take, advance;

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && result_stall);

    // A restart clears the point before it is emitted.
    assign eff_x = in_item_reg.start_new ? '0 : cur_x_reg;
    assign eff_y = in_item_reg.start_new ? '0 : cur_y_reg;

    fern_proj_unit #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_proj (
        .x    (eff_x),
        .y    (eff_y),
        .proj (proj)
    );

    fern_map_unit #(
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_map (
        .draw   (in_item_reg.draw),
        .x      (eff_x),
        .y      (eff_y),
        .next_x (cur_x_next),
        .next_y (cur_y_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_item_reg <= proj;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

[hw/rtl/fern_map_unit.sv]
// ----------------------------------------------------------------------------
// fern_map_unit
// Applies one of the four affine maps, chosen by the draw, to the current
// point and returns the saturated next point.
// ----------------------------------------------------------------------------
module fern_map_unit #(
    parameter int STATE_FRAC_BITS = 18
) (
    input  logic [6:0]                           draw,
    input  logic signed [fern_pkg::STATE_W-1:0]  x,
    input  logic signed [fern_pkg::STATE_W-1:0]  y,
    output logic signed [fern_pkg::STATE_W-1:0]  next_x,
    output logic signed [fern_pkg::STATE_W-1:0]  next_y
);

    localparam int AW = fern_pkg::ADD_W;
    localparam int PW = fern_pkg::PROD_W;
    localparam int SW = fern_pkg::SUM_W;
    localparam int SH = 32 - STATE_FRAC_BITS;
    localparam logic signed [63:0] CBIAS = 64'sd1 <<< (SH - 1);
    localparam logic signed [AW-1:0] ADD_160 = AW'((fern_pkg::C32_1_60 + CBIAS) >>> SH);
    localparam logic signed [AW-1:0] ADD_044 = AW'((fern_pkg::C32_0_44 + CBIAS) >>> SH);
    localparam logic signed [SW-1:0] RBIAS = SW'(64'sd1 <<< (fern_pkg::COEF_FRAC - 1));

    fern_pkg::map_coef_t  coef;
    logic signed [AW-1:0] add_y;
    logic signed [PW-1:0] pax, pbx, pay, pby;
    logic signed [SW-1:0] sum_x, sum_y, rnd_x, rnd_y;

    assign coef = fern_pkg::map_select(draw);

    always_comb
    begin
        unique case (coef.add_sel)
            fern_pkg::ADD_1_60: add_y = ADD_160;
            fern_pkg::ADD_0_44: add_y = ADD_044;
            default:            add_y = '0;
        endcase
    end

    assign pax = PW'(x) * PW'(coef.ax);
    assign pbx = PW'(y) * PW'(coef.bx);
    assign pay = PW'(x) * PW'(coef.ay);
    assign pby = PW'(y) * PW'(coef.by);

    assign sum_x = SW'(pax) + SW'(pbx);
    assign sum_y = SW'(pay) + SW'(pby);

    // Round half up to the state's fraction bits.
    assign rnd_x = (sum_x + RBIAS) >>> fern_pkg::COEF_FRAC;
    assign rnd_y = ((sum_y + RBIAS) >>> fern_pkg::COEF_FRAC) + SW'(add_y);

    assign next_x = fern_pkg::sat_state(rnd_x);
    assign next_y = fern_pkg::sat_state(rnd_y);

endmodule

[hw/rtl/fern_proj_unit.sv]
// ----------------------------------------------------------------------------
// fern_proj_unit
// Projects the current point to screen coordinates and a red level.
// ----------------------------------------------------------------------------
module fern_proj_unit #(
    parameter int STATE_FRAC_BITS = 18
) (
    input  logic signed [fern_pkg::STATE_W-1:0] x,
    input  logic signed [fern_pkg::STATE_W-1:0] y,
    output fern_pkg::out_item_t                 proj
);

    localparam int QW  = fern_pkg::PROJ_W;
    localparam int OSH = STATE_FRAC_BITS + fern_pkg::COEF_FRAC - fern_pkg::OUT_FRAC;
    localparam logic signed [QW-1:0] OBIAS = QW'(64'sd1 <<< (OSH - 1));

    logic signed [QW-1:0] px, py, pr;
    logic signed [QW-1:0] rx, ry, rr;

    assign px = QW'(x) * fern_pkg::K_SCALE;
    assign py = QW'(y) * fern_pkg::K_SCALE;
    assign pr = QW'(y) * fern_pkg::K_RED;

    assign rx = ((px + OBIAS) >>> OSH) - fern_pkg::OFF_X;
    assign ry = ((py + OBIAS) >>> OSH) - fern_pkg::OFF_Y;
    assign rr = (pr + OBIAS) >>> OSH;

    assign proj.point_x   = fern_pkg::sat_out(rx);
    assign proj.point_y   = fern_pkg::sat_out(ry);
    assign proj.red_level = fern_pkg::clamp_red(rr);

endmodule
